// ===== hw/rtl/gnc_pkg.sv =====
// ----------------------------------------------------------------------------
// gnc_pkg: grid neighbor consistency check package
// Field widths, register codes, reset values and stage flag type shared by
// the check pipeline and its port checker.
// ----------------------------------------------------------------------------
package gnc_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_W   = 25;            // signed Q16.8 grid coordinate
  localparam int ENTRY_W   = 2 * COORD_W;   // packed {x, y} in the row store
  localparam int DIFF_W    = 27;            // src + step - neighbor, exact
  localparam int MAG_W     = 26;            // |diff| < 3 * 2^24
  localparam int SQ_W      = 2 * MAG_W;     // one squared component
  localparam int SUM_W     = SQ_W + 1;      // squared distance
  localparam int TOL_W     = 20;            // unsigned Q12.8 tolerance
  localparam int TOLSQ_W   = 2 * TOL_W;     // tolerance squared
  localparam int TOTAL_W   = 27;            // running mismatch count
  localparam int NEW_W     = 2;             // mismatches per entry
  localparam int HEIGHT_W  = 16;            // grid_height register
  localparam int WREG_W    = 11;            // grid_width register

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_RIGHT_STEP_X = 3'd2,
    REG_RIGHT_STEP_Y = 3'd3,
    REG_DOWN_STEP_X  = 3'd4,
    REG_DOWN_STEP_Y  = 3'd5,
    REG_TOLERANCE    = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [WREG_W-1:0]   WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd1024;
  localparam logic [TOL_W-1:0]    TOL_RST    = 20'd256;

  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

  // Per-request control carried down the pipeline
  typedef struct packed {
    logic right_en;   // right check armed (source = left entry)
    logic down_en;    // down check armed (source = entry above)
    logic bad;        // this entry is a source with x != 0, y == 0
    logic done;       // last entry of the frame
    logic fresh;      // frame restarted before this entry (geometry change)
  } chk_flags_t;

endpackage

// ===== hw/rtl/grid_neighbor_consistency_check.sv =====
// ----------------------------------------------------------------------------
// grid_neighbor_consistency_check: neighbor distance check over a point grid
// Streams grid entries in raster order, compares each known entry against its
// left and upper neighbor plus a configured step and counts distance misses.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in_     | in        | in_valid / in_stall  | entry_x, entry_y
//   out_    | out       | out_valid/ out_stall | new_mismatches, mismatch_total,
//           |           |                      | bad_entry, frame_done
//   cfg_    | in        | cfg_wr_en            | cfg_index, cfg_wr_data
//
// One request per clock sustained while out_stall is low. A result passes
// the accept/row-store read, magnitude, square, and compare and count
// registers in turn; every stage holds on its own, so bubbles collapse under stall.
// The row store is a read-first single-port RAM: the entry above is read and
// the current entry written at the same address in the accepting cycle, so no
// forwarding is needed. No clearing pass: the store is never read before it
// is written in a well-formed frame. Reset (rst_n low, synchronous) clears the
// counters, the frame total and the sticky flag, and sets the configuration to its reset values.
//
module grid_neighbor_consistency_check #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // request channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [gnc_pkg::COORD_W-1:0]      in_entry_x,
  input  logic signed [gnc_pkg::COORD_W-1:0]      in_entry_y,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic        [gnc_pkg::NEW_W-1:0]        out_new_mismatches,
  output logic        [gnc_pkg::TOTAL_W-1:0]      out_mismatch_total,
  output logic                                    out_bad_entry,
  output logic                                    out_frame_done,
  // configuration
  input  logic                                    cfg_wr_en,
  input  logic        [gnc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [gnc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column index
  localparam int WCW  = $clog2(MAX_WIDTH + 1);                     // holds width
  localparam int CMPW = (WCW > gnc_pkg::WREG_W) ? WCW : gnc_pkg::WREG_W;
  localparam int HW   = gnc_pkg::HEIGHT_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [gnc_pkg::WREG_W-1:0]   grid_width_r;
  logic        [HW-1:0]                grid_height_r;
  logic signed [gnc_pkg::COORD_W-1:0]  right_step_x_r, right_step_y_r;
  logic signed [gnc_pkg::COORD_W-1:0]  down_step_x_r,  down_step_y_r;
  logic        [gnc_pkg::TOL_W-1:0]    tolerance_r;
  logic        [gnc_pkg::TOLSQ_W-1:0]  tol_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= gnc_pkg::WIDTH_RST;
      grid_height_r  <= gnc_pkg::HEIGHT_RST;
      right_step_x_r <= '0;
      right_step_y_r <= '0;
      down_step_x_r  <= '0;
      down_step_y_r  <= '0;
      tolerance_r    <= gnc_pkg::TOL_RST;
    end else if (cfg_wr_en) begin
      unique case (gnc_pkg::cfg_reg_t'(cfg_index))
        gnc_pkg::REG_GRID_WIDTH:   grid_width_r   <= cfg_wr_data[gnc_pkg::WREG_W-1:0];
        gnc_pkg::REG_GRID_HEIGHT:  grid_height_r  <= cfg_wr_data[HW-1:0];
        gnc_pkg::REG_RIGHT_STEP_X: right_step_x_r <= cfg_wr_data;
        gnc_pkg::REG_RIGHT_STEP_Y: right_step_y_r <= cfg_wr_data;
        gnc_pkg::REG_DOWN_STEP_X:  down_step_x_r  <= cfg_wr_data;
        gnc_pkg::REG_DOWN_STEP_Y:  down_step_y_r  <= cfg_wr_data;
        gnc_pkg::REG_TOLERANCE:    tolerance_r    <= cfg_wr_data[gnc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // tolerance squared, kept beside the register (the user must change config only when idle; not enforced here)
  always_ff @(posedge clk) begin
    tol_sq_r <= gnc_pkg::TOLSQ_W'(tolerance_r) * gnc_pkg::TOLSQ_W'(tolerance_r);
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: each stage loads when it is empty or draining
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic out_ld, s3_free, s2_free, s1_free, in_fire;

  assign out_ld  = !out_valid_r || !out_stall;
  assign s3_free = !s3_v_r || out_ld;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_free = !s1_v_r || s2_free;
  assign in_stall = !s1_free;
  assign in_fire  = in_valid && s1_free;

  // --------------------------------------------------------------------------
  // Stage 0: raster position, check enables, row store access
  // --------------------------------------------------------------------------
  logic        [CW-1:0]               col_r, col_nxt;
  logic        [HW-1:0]               row_r, row_nxt;
  logic signed [gnc_pkg::COORD_W-1:0] left_x_r, left_y_r, left_x_nxt, left_y_nxt;

  logic [CMPW-1:0]        width_ext, w_wide;
  logic [WCW-1:0]         w_eff, w_m1;
  logic [HW-1:0]          h_eff, h_m1;
  logic                   col_wrap, new_frame, last_c, last_r;
  logic [HW:0]            row_adv;
  logic [CW-1:0]          c_idx;
  logic [HW-1:0]          r_idx;
  logic signed [gnc_pkg::COORD_W-1:0] left_x_src, left_y_src;
  gnc_pkg::chk_flags_t    s0_flags;

  always_comb begin
    // width clamped to [2, MAX_WIDTH], height to at least 2
    width_ext = CMPW'(grid_width_r);
    if (width_ext < CMPW'(2)) begin
      w_wide = CMPW'(2);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      w_wide = CMPW'(MAX_WIDTH);
    end else begin
      w_wide = width_ext;
    end
    w_eff = WCW'(w_wide);
    w_m1  = w_eff - WCW'(1);
    h_eff = (grid_height_r < HW'(2)) ? HW'(2) : grid_height_r;
    h_m1  = h_eff - HW'(1);

    // geometry shrunk mid-frame: start a new row, maybe a new frame
    col_wrap  = WCW'(col_r) >= w_eff;
    row_adv   = {1'b0, row_r} + (HW+1)'(col_wrap);
    new_frame = row_adv >= {1'b0, h_eff};
    c_idx     = (col_wrap || new_frame) ? '0 : col_r;
    r_idx     = new_frame ? '0 : row_adv[HW-1:0];
    left_x_src = new_frame ? '0 : left_x_r;
    left_y_src = new_frame ? '0 : left_y_r;

    last_c = WCW'(c_idx) == w_m1;
    last_r = r_idx == h_m1;

    s0_flags.right_en = (c_idx != '0) && !last_r && (left_x_src != '0) && (in_entry_x != '0);
    s0_flags.down_en  = (r_idx != '0) && !last_c && (in_entry_x != '0);   // above.x later
    s0_flags.bad      = !last_c && !last_r && (in_entry_x != '0) && (in_entry_y == '0);
    s0_flags.done     = last_c && last_r;
    s0_flags.fresh    = new_frame;

    // position and left neighbor after this request
    col_nxt    = col_r;
    row_nxt    = row_r;
    left_x_nxt = left_x_r;
    left_y_nxt = left_y_r;
    if (in_fire) begin
      priority if (s0_flags.done) begin
        col_nxt    = '0;
        row_nxt    = '0;
        left_x_nxt = '0;
        left_y_nxt = '0;
      end else if (last_c) begin
        col_nxt    = '0;
        row_nxt    = r_idx + HW'(1);
        left_x_nxt = '0;
        left_y_nxt = '0;
      end else begin
        col_nxt    = c_idx + CW'(1);
        row_nxt    = r_idx;
        left_x_nxt = in_entry_x;
        left_y_nxt = in_entry_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      left_x_r <= '0;
      left_y_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      left_x_r <= left_x_nxt;
      left_y_r <= left_y_nxt;
    end
  end

  // Row store: read-first, entry above comes out as this column is rewritten
  logic [gnc_pkg::ENTRY_W-1:0] row_mem [MAX_WIDTH];
  logic [gnc_pkg::ENTRY_W-1:0] s1_up_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_up_r        <= row_mem[c_idx];
      row_mem[c_idx] <= {in_entry_x, in_entry_y};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: differences against the expected neighbor position, magnitudes
  // --------------------------------------------------------------------------
  gnc_pkg::chk_flags_t                s1_flags_r;
  logic signed [gnc_pkg::COORD_W-1:0] s1_cur_x_r, s1_cur_y_r, s1_left_x_r, s1_left_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flags_r  <= s0_flags;
      s1_cur_x_r  <= in_entry_x;
      s1_cur_y_r  <= in_entry_y;
      s1_left_x_r <= left_x_src;
      s1_left_y_r <= left_y_src;
    end
  end

  function automatic logic [gnc_pkg::MAG_W-1:0] magnitude(
    input logic signed [gnc_pkg::DIFF_W-1:0] d
  );
    logic [gnc_pkg::DIFF_W-1:0] a;
    a = d[gnc_pkg::DIFF_W-1] ? gnc_pkg::DIFF_W'(-d) : gnc_pkg::DIFF_W'(d);
    return a[gnc_pkg::MAG_W-1:0];
  endfunction

  logic signed [gnc_pkg::COORD_W-1:0] up_x, up_y;
  logic signed [gnc_pkg::DIFF_W-1:0]  diff_rx, diff_ry, diff_dx, diff_dy;
  gnc_pkg::chk_flags_t                s1_flags_out;

  always_comb begin
    up_x = s1_up_r[gnc_pkg::ENTRY_W-1:gnc_pkg::COORD_W];
    up_y = s1_up_r[gnc_pkg::COORD_W-1:0];
    diff_rx = gnc_pkg::DIFF_W'(s1_left_x_r) + gnc_pkg::DIFF_W'(right_step_x_r)
            - gnc_pkg::DIFF_W'(s1_cur_x_r);
    diff_ry = gnc_pkg::DIFF_W'(s1_left_y_r) + gnc_pkg::DIFF_W'(right_step_y_r)
            - gnc_pkg::DIFF_W'(s1_cur_y_r);
    diff_dx = gnc_pkg::DIFF_W'(up_x) + gnc_pkg::DIFF_W'(down_step_x_r)
            - gnc_pkg::DIFF_W'(s1_cur_x_r);
    diff_dy = gnc_pkg::DIFF_W'(up_y) + gnc_pkg::DIFF_W'(down_step_y_r)
            - gnc_pkg::DIFF_W'(s1_cur_y_r);
    s1_flags_out         = s1_flags_r;
    s1_flags_out.down_en = s1_flags_r.down_en && (up_x != '0);   // unknown above
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares
  // --------------------------------------------------------------------------
  gnc_pkg::chk_flags_t        s2_flags_r;
  logic [gnc_pkg::MAG_W-1:0]  s2_rx_r, s2_ry_r, s2_dx_r, s2_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_flags_r <= s1_flags_out;
      s2_rx_r    <= magnitude(diff_rx);
      s2_ry_r    <= magnitude(diff_ry);
      s2_dx_r    <= magnitude(diff_dx);
      s2_dy_r    <= magnitude(diff_dy);
    end
  end

  gnc_pkg::chk_flags_t       s3_flags_r;
  logic [gnc_pkg::SQ_W-1:0]  s3_rx_r, s3_ry_r, s3_dx_r, s3_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_flags_r <= s2_flags_r;
      s3_rx_r    <= gnc_pkg::SQ_W'(s2_rx_r) * gnc_pkg::SQ_W'(s2_rx_r);
      s3_ry_r    <= gnc_pkg::SQ_W'(s2_ry_r) * gnc_pkg::SQ_W'(s2_ry_r);
      s3_dx_r    <= gnc_pkg::SQ_W'(s2_dx_r) * gnc_pkg::SQ_W'(s2_dx_r);
      s3_dy_r    <= gnc_pkg::SQ_W'(s2_dy_r) * gnc_pkg::SQ_W'(s2_dy_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: distance compare, frame total (saturating), sticky bad flag
  // --------------------------------------------------------------------------
  logic [gnc_pkg::TOTAL_W-1:0] total_r, total_nxt, total_base;
  logic                        err_r, err_nxt;
  logic [gnc_pkg::SUM_W-1:0]   dist_r, dist_d;
  logic                        fail_r, fail_d;
  logic [gnc_pkg::NEW_W-1:0]   n_new;
  logic [gnc_pkg::TOTAL_W:0]   total_sum;

  always_comb begin
    dist_r = gnc_pkg::SUM_W'(s3_rx_r) + gnc_pkg::SUM_W'(s3_ry_r);
    dist_d = gnc_pkg::SUM_W'(s3_dx_r) + gnc_pkg::SUM_W'(s3_dy_r);
    fail_r = s3_flags_r.right_en && (dist_r > gnc_pkg::SUM_W'(tol_sq_r));
    fail_d = s3_flags_r.down_en  && (dist_d > gnc_pkg::SUM_W'(tol_sq_r));
    n_new  = gnc_pkg::NEW_W'(fail_r) + gnc_pkg::NEW_W'(fail_d);

    total_base = s3_flags_r.fresh ? '0 : total_r;
    total_sum  = {1'b0, total_base} + (gnc_pkg::TOTAL_W+1)'(n_new);
    total_nxt  = total_sum[gnc_pkg::TOTAL_W] ? gnc_pkg::TOTAL_MAX
                                             : total_sum[gnc_pkg::TOTAL_W-1:0];
    err_nxt    = (!s3_flags_r.fresh && err_r) || s3_flags_r.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
      err_r       <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= s3_v_r;
      if (s3_v_r) begin
        // frame end clears after the result is formed
        total_r <= s3_flags_r.done ? '0 : total_nxt;
        err_r   <= s3_flags_r.done ? 1'b0 : err_nxt;
      end
    end
  end

  logic [gnc_pkg::NEW_W-1:0]   out_new_r;
  logic [gnc_pkg::TOTAL_W-1:0] out_total_r;
  logic                        out_bad_r, out_done_r;

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_new_r   <= n_new;
      out_total_r <= total_nxt;
      out_bad_r   <= err_nxt;
      out_done_r  <= s3_flags_r.done;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_new_mismatches = out_new_r;
  assign out_mismatch_total = out_total_r;
  assign out_bad_entry      = out_bad_r;
  assign out_frame_done     = out_done_r;

endmodule

// ===== hw/rtl/gnc_checker.sv =====
// ----------------------------------------------------------------------------
// gnc_checker: result port checks for grid_neighbor_consistency_check
// Watches the result channel for hold, reset and running-total consistency.
// ----------------------------------------------------------------------------
module gnc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [gnc_pkg::NEW_W-1:0]          out_new_mismatches,
  input logic [gnc_pkg::TOTAL_W-1:0]        out_mismatch_total,
  input logic                               out_bad_entry,
  input logic                               out_frame_done
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mismatch_total)
      && $stable(out_new_mismatches) && $stable(out_bad_entry) && $stable(out_frame_done))
    else $error("result changed while stalled");

  // pipeline empties on reset
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // total covers this entry's misses; at most two per entry
  a_total_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_new_mismatches != 2'd3
      && out_mismatch_total >= gnc_pkg::TOTAL_W'(out_new_mismatches))
    else $error("mismatch total below new mismatches");

  // back-to-back results inside a frame: total accumulates
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_frame_done ##1 out_valid && !out_stall)
      |-> out_mismatch_total == $past(out_mismatch_total)
            + gnc_pkg::TOTAL_W'(out_new_mismatches)
          || out_mismatch_total == gnc_pkg::TOTAL_MAX)
    else $error("mismatch total did not accumulate");

  // bad-entry flag sticks within a frame
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_bad_entry && !out_frame_done ##1 out_valid && !out_stall)
      |-> out_bad_entry)
    else $error("bad entry flag dropped mid frame");

endmodule

bind grid_neighbor_consistency_check gnc_checker u_gnc_checker (.*);
